// ===== rtl/core/tsr_pkg.sv =====
package tsr_pkg;

    localparam int COORD_BITS_DEF = 13;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_BITS       = 13;
    localparam int PX_BITS        = 12;

    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CFG_BITS-1:0] DIM_MAX      = 13'd4096;
    localparam logic [CFG_BITS-1:0] DIM_MIN      = 13'd1;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // input commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // divider operand select
    localparam logic [1:0] DIV_MID   = 2'd0;
    localparam logic [1:0] DIV_LEFT  = 2'd1;
    localparam logic [1:0] DIV_RIGHT = 2'd2;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       div_start;
        logic [1:0] div_sel;
        logic       mid_x3;
        logic       mid_wr;
        logic       slope_clr;
        logic       slope_l_wr;
        logic       slope_r_wr;
        logic       row_start;
        logic       row_inc;
        logic       half_next;
        logic       mul;
        logic       span_wr;
        logic       col_inc;
        logic       act_clr;
        logic       out_load;
    } tsr_cmd_t;

    typedef struct packed {
        logic d_zero;
        logic dy_zero;
        logic div_done;
        logic row_gt_hi;
        logic span_ok;
        logic col_lt_end;
        logic half;
        logic active;
    } tsr_sts_t;

    // zero acts as one, anything above the max acts as the max
    function automatic logic [CFG_BITS-1:0] eff_dim(input logic [CFG_BITS-1:0] v);
        logic [CFG_BITS-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_MIN;
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/tsr_div.sv =====
module tsr_div
    import tsr_pkg::*;
#(
    parameter int NW  = 31,
    parameter int DNW = 14
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0]  numer,
    input  logic signed [DNW-1:0] denom,
    output logic                 done,
    output logic signed [NW-1:0]  quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg;
    logic [DNW-1:0]  rem_reg;
    logic [DNW-1:0]  den_reg;
    logic            neg_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    logic [NW-1:0]   num_mag;
    logic [DNW-1:0]  den_mag;
    logic [DNW:0]    trial;
    logic            fits;

    assign num_mag = numer[NW-1] ? NW'(-numer) : NW'(numer);
    assign den_mag = denom[DNW-1] ? DNW'(-denom) : DNW'(denom);

    // one quotient bit per cycle, restoring
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num_mag;
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= numer[NW-1] ^ denom[DNW-1];
        end else if (busy_reg) begin
            rem_reg <= fits ? DNW'(trial - {1'b0, den_reg}) : trial[DNW-1:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== rtl/core/tsr_ctrl.sv =====
module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_cmd,
    output logic     m_valid,
    input  logic     m_ready,
    input  tsr_sts_t sts,
    output tsr_cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LCHK  = 4'd1;
    localparam logic [3:0] S_MID   = 4'd2;
    localparam logic [3:0] S_SETUP = 4'd3;
    localparam logic [3:0] S_DIVL  = 4'd4;
    localparam logic [3:0] S_DIVR  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       from_step_reg, from_step_next;
    logic       m_valid_reg;
    logic [3:0] seek_done;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign seek_done = from_step_reg ? S_EMIT : S_IDLE;

    // sequencer
    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        from_step_next = from_step_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_LOAD) begin
                        cmd.load       = 1'b1;
                        from_step_next = 1'b0;
                        state_next     = S_LCHK;
                    end else begin
                        cmd.step       = 1'b1;
                        from_step_next = 1'b1;
                        if (!sts.active) begin
                            state_next = S_EMIT;
                        end else if (sts.col_lt_end) begin
                            cmd.col_inc = 1'b1;
                            state_next  = S_EMIT;
                        end else begin
                            cmd.row_inc = 1'b1;
                            state_next  = S_MUL;
                        end
                    end
                end
            end
            S_LCHK: begin
                if (sts.d_zero) begin
                    cmd.mid_x3 = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_MID;
                    state_next    = S_MID;
                end
            end
            S_MID: begin
                if (sts.div_done) begin
                    cmd.mid_wr = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                if (sts.dy_zero) begin
                    cmd.slope_clr = 1'b1;
                    cmd.row_start = 1'b1;
                    state_next    = S_MUL;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_LEFT;
                    state_next    = S_DIVL;
                end
            end
            S_DIVL: begin
                if (sts.div_done) begin
                    cmd.slope_l_wr = 1'b1;
                    cmd.div_start  = 1'b1;
                    cmd.div_sel    = DIV_RIGHT;
                    state_next     = S_DIVR;
                end
            end
            S_DIVR: begin
                if (sts.div_done) begin
                    cmd.slope_r_wr = 1'b1;
                    cmd.row_start  = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL: begin
                if (sts.row_gt_hi) begin
                    if (sts.half) begin
                        cmd.act_clr = 1'b1;
                        state_next  = seek_done;
                    end else begin
                        cmd.half_next = 1'b1;
                        state_next    = S_SETUP;
                    end
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (sts.span_ok) begin
                    cmd.span_wr = 1'b1;
                    state_next  = seek_done;
                end else begin
                    cmd.row_inc = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            from_step_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            from_step_reg <= from_step_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // a result only overwrites the output beat once it is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result written over a pending beat");

    // divider finishes only while a divide is awaited
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == S_MID || state_reg == S_DIVL || state_reg == S_DIVR))
        else $error("divider done outside a divide wait");

    // only step items lead to a result
    a_emit_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> from_step_reg)
        else $error("result pending after a load");

    // a found span leaves the triangle active
    a_span_act: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.span_wr |=> sts.active)
        else $error("span found but triangle inactive");

endmodule

// ===== rtl/core/tsr_dp.sv =====
module tsr_dp
    import tsr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tsr_cmd_t                     cmd,
    output tsr_sts_t                     sts,
    input  logic signed [COORD_BITS-1:0] s_vertex_a_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_a_y,
    input  logic signed [COORD_BITS-1:0] s_vertex_b_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_b_y,
    input  logic signed [COORD_BITS-1:0] s_vertex_c_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_c_y,
    input  logic                         cfg_valid,
    input  logic                         cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data,
    output logic [PX_BITS-1:0]           m_px_x,
    output logic [PX_BITS-1:0]           m_px_y,
    output logic                         m_has_pixel,
    output logic                         m_last
);

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int RW   = ((CW > CFG_BITS) ? CW : CFG_BITS) + 1;
    localparam int NUMW = ((2 * CW + 3 > CW + 1 + FRAC_BITS) ? 2 * CW + 3
                                                            : CW + 1 + FRAC_BITS) + 1;
    localparam int QW   = (NUMW > 33) ? NUMW : 33;
    localparam int MW   = 32 + RW + 1;
    localparam int SW   = MW + 1;
    localparam int XW   = SW - FRAC_BITS;

    // frame size
    logic [CFG_BITS-1:0] width_reg, height_reg;
    logic [CFG_BITS-1:0] w_eff, h_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_WIDTH) begin
                width_reg <= cfg_data;
            end else begin
                height_reg <= cfg_data;
            end
        end
    end

    assign w_eff = eff_dim(width_reg);
    assign h_eff = eff_dim(height_reg);

    // sort the incoming vertices by row, highest first
    logic signed [CW-1:0] sx1, sy1, sx2, sy2, sx3, sy3;

    always_comb begin : sort_blk
        logic signed [CW-1:0] tx, ty;
        tx  = '0;
        ty  = '0;
        sx1 = s_vertex_a_x;
        sy1 = s_vertex_a_y;
        sx2 = s_vertex_b_x;
        sy2 = s_vertex_b_y;
        sx3 = s_vertex_c_x;
        sy3 = s_vertex_c_y;
        if (sy1 < sy2) begin
            tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
        end
        if (sy2 < sy3) begin
            tx = sx2; ty = sy2; sx2 = sx3; sy2 = sy3; sx3 = tx; sy3 = ty;
        end
        if (sy1 < sy2) begin
            tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
        end
    end

    // triangle state
    logic signed [CW-1:0]  vx_reg [3];
    logic signed [CW-1:0]  vy_reg [3];
    logic signed [CW-1:0]  mid_reg;
    logic                  half_reg;
    logic signed [31:0]    slope_l_reg, slope_r_reg;
    logic signed [RW-1:0]  row_reg;
    logic [PX_BITS-1:0]    col_reg, end_reg;
    logic                  active_reg;
    logic signed [MW-1:0]  prod_l_reg, prod_r_reg;
    logic [PX_BITS-1:0]    pend_x_reg, pend_y_reg;
    logic                  pend_has_reg;
    logic [PX_BITS-1:0]    out_x_reg, out_y_reg;
    logic                  out_has_reg, out_last_reg;

    // derived geometry
    logic signed [CW-1:0]  base_l, base_r, apex_x, apex_y, lo, hi;
    logic signed [DW-1:0]  d_full, dy, dx_l, dx_r, dy23, dx13;
    logic signed [RW-1:0]  lo_ext, hi_ext, ht_m1, hi_c, row_first;

    assign base_l = (vx_reg[1] < mid_reg) ? vx_reg[1] : mid_reg;
    assign base_r = (vx_reg[1] < mid_reg) ? mid_reg : vx_reg[1];
    assign apex_x = half_reg ? vx_reg[2] : vx_reg[0];
    assign apex_y = half_reg ? vy_reg[2] : vy_reg[0];
    assign lo     = (apex_y < vy_reg[1]) ? apex_y : vy_reg[1];
    assign hi     = (apex_y < vy_reg[1]) ? vy_reg[1] : apex_y;

    assign d_full = DW'(vy_reg[0]) - DW'(vy_reg[2]);
    assign dy     = DW'(apex_y) - DW'(vy_reg[1]);
    assign dx_l   = DW'(apex_x) - DW'(base_l);
    assign dx_r   = DW'(apex_x) - DW'(base_r);
    assign dy23   = DW'(vy_reg[1]) - DW'(vy_reg[2]);
    assign dx13   = DW'(vx_reg[0]) - DW'(vx_reg[2]);

    assign lo_ext    = RW'(lo);
    assign hi_ext    = RW'(hi);
    assign ht_m1     = $signed({{(RW-CFG_BITS){1'b0}}, h_eff}) - RW'(1);
    assign hi_c      = (hi_ext > ht_m1) ? ht_m1 : hi_ext;
    assign row_first = lo_ext[RW-1] ? '0 : lo_ext;

    // divider operands
    logic signed [NUMW-1:0] mid_p1, mid_p2, num_mid, num_l, num_r, div_num;
    logic signed [NUMW-1:0] dx_l_ext, dx_r_ext;
    logic signed [DW-1:0]   div_den;
    logic                   div_done;
    logic signed [NUMW-1:0] div_quo;

    assign mid_p1   = NUMW'(dy23) * NUMW'(dx13);
    assign mid_p2   = NUMW'(vx_reg[2]) * NUMW'(d_full);
    assign num_mid  = mid_p1 + mid_p2;
    assign dx_l_ext = NUMW'(dx_l);
    assign dx_r_ext = NUMW'(dx_r);
    assign num_l    = dx_l_ext <<< FRAC_BITS;
    assign num_r    = dx_r_ext <<< FRAC_BITS;

    always_comb begin
        case (cmd.div_sel)
            DIV_MID: begin
                div_num = num_mid;
                div_den = d_full;
            end
            DIV_LEFT: begin
                div_num = num_l;
                div_den = dy;
            end
            default: begin
                div_num = num_r;
                div_den = dy;
            end
        endcase
    end

    tsr_div #(
        .NW  (NUMW),
        .DNW (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .numer   (div_num),
        .denom   (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // clamp the quotient to 32 bits
    logic signed [QW-1:0]  q_ext;
    logic [QW-32:0]        q_top;
    logic signed [31:0]    q_sat;

    assign q_ext = QW'(div_quo);
    assign q_top = q_ext[QW-1:31];
    assign q_sat = ((&q_top) || (~|q_top)) ? q_ext[31:0]
                 : (q_ext[QW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

    // edge columns for the current row
    logic signed [RW:0]   row_d;
    logic signed [MW-1:0] prod_l_next, prod_r_next;
    logic signed [SW-1:0] bl_ext, br_ext, sum_l, sum_r, sum_l_rnd, sum_r_rnd;
    logic signed [SW-1:0] round_add;
    logic signed [XW-1:0] xl, xr, w_s, xl_c, xr_c;
    logic                 span_ok;

    assign row_d       = (RW+1)'(row_reg) - (RW+1)'(vy_reg[1]);
    assign prod_l_next = MW'(slope_l_reg) * MW'(row_d);
    assign prod_r_next = MW'(slope_r_reg) * MW'(row_d);

    assign bl_ext    = SW'(base_l);
    assign br_ext    = SW'(base_r);
    assign sum_l     = SW'(prod_l_reg) + (bl_ext <<< FRAC_BITS);
    assign sum_r     = SW'(prod_r_reg) + (br_ext <<< FRAC_BITS);
    assign round_add = $signed({{(SW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}});
    // divide by one unit, truncating toward zero
    assign sum_l_rnd = sum_l[SW-1] ? (sum_l + round_add) : sum_l;
    assign sum_r_rnd = sum_r[SW-1] ? (sum_r + round_add) : sum_r;
    assign xl        = XW'(sum_l_rnd >>> FRAC_BITS);
    assign xr        = XW'(sum_r_rnd >>> FRAC_BITS);

    // clip to the frame
    assign w_s     = $signed({{(XW-CFG_BITS){1'b0}}, w_eff});
    assign xl_c    = xl[XW-1] ? '0 : xl;
    assign xr_c    = (xr >= w_s) ? (w_s - XW'(1)) : xr;
    assign span_ok = !(xl >= w_s) && !xr[XW-1] && (xl_c <= xr_c);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else if (cmd.load || cmd.act_clr) begin
            active_reg <= 1'b0;
        end else if (cmd.span_wr) begin
            active_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            vx_reg[0]   <= sx1;
            vy_reg[0]   <= sy1;
            vx_reg[1]   <= sx2;
            vy_reg[1]   <= sy2;
            vx_reg[2]   <= sx3;
            vy_reg[2]   <= sy3;
            half_reg    <= 1'b0;
            slope_l_reg <= '0;
            slope_r_reg <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            end_reg     <= '0;
        end
        if (cmd.mid_x3) begin
            mid_reg <= vx_reg[2];
        end else if (cmd.mid_wr) begin
            mid_reg <= div_quo[CW-1:0];
        end
        if (cmd.half_next) begin
            half_reg <= 1'b1;
        end
        if (cmd.slope_clr) begin
            slope_l_reg <= '0;
            slope_r_reg <= '0;
        end
        if (cmd.slope_l_wr) begin
            slope_l_reg <= q_sat;
        end
        if (cmd.slope_r_wr) begin
            slope_r_reg <= q_sat;
        end
        if (cmd.row_start) begin
            row_reg <= row_first;
        end else if (cmd.row_inc) begin
            row_reg <= row_reg + RW'(1);
        end
        if (cmd.mul) begin
            prod_l_reg <= prod_l_next;
            prod_r_reg <= prod_r_next;
        end
        if (cmd.span_wr) begin
            col_reg <= xl_c[PX_BITS-1:0];
            end_reg <= xr_c[PX_BITS-1:0];
        end else if (cmd.col_inc) begin
            col_reg <= col_reg + PX_BITS'(1);
        end
        // pixel named by this step, taken before advancing
        if (cmd.step) begin
            pend_x_reg   <= active_reg ? col_reg : '0;
            pend_y_reg   <= active_reg ? row_reg[PX_BITS-1:0] : '0;
            pend_has_reg <= active_reg;
        end
        if (cmd.out_load) begin
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_has_reg  <= pend_has_reg;
            out_last_reg <= pend_has_reg & ~active_reg;
        end
    end

    assign sts.d_zero     = (vy_reg[0] == vy_reg[2]);
    assign sts.dy_zero    = (apex_y == vy_reg[1]);
    assign sts.div_done   = div_done;
    assign sts.row_gt_hi  = (row_reg > hi_c);
    assign sts.span_ok    = span_ok;
    assign sts.col_lt_end = (col_reg < end_reg);
    assign sts.half       = half_reg;
    assign sts.active     = active_reg;

    assign m_px_x      = out_x_reg;
    assign m_px_y      = out_y_reg;
    assign m_has_pixel = out_has_reg;
    assign m_last      = out_last_reg;

endmodule

// ===== rtl/core/triangle_scanline_rasterizer.sv =====
// Load: sort plus one divide for the middle column (none, and no halves, if top and bottom rows match),
//   then per half two slope divides (none for a flat half) and the row search.
// Step inside a span: the column advances and the result goes out through S_EMIT; at a span end the row
//   search runs first (S_MUL and S_CHK per row tried, divides again when entering the lower half).
// One item in flight at a time; the output register lets the next item in while a result waits.
// Synchronous active-low reset: no triangle, frame 640 x 480, no pending result.
module triangle_scanline_rasterizer
    import tsr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic signed [COORD_BITS-1:0] s_vertex_a_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_a_y,
    input  logic signed [COORD_BITS-1:0] s_vertex_b_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_b_y,
    input  logic signed [COORD_BITS-1:0] s_vertex_c_x,
    input  logic signed [COORD_BITS-1:0] s_vertex_c_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [PX_BITS-1:0]           m_px_x,
    output logic [PX_BITS-1:0]           m_px_y,
    output logic                         m_has_pixel,
    output logic                         m_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [CFG_BITS-1:0]          cfg_data
);

    tsr_cmd_t cmd;
    tsr_sts_t sts;

    assign cfg_ready = 1'b1;

    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tsr_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_vertex_a_x (s_vertex_a_x),
        .s_vertex_a_y (s_vertex_a_y),
        .s_vertex_b_x (s_vertex_b_x),
        .s_vertex_b_y (s_vertex_b_y),
        .s_vertex_c_x (s_vertex_c_x),
        .s_vertex_c_y (s_vertex_c_y),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_px_x       (m_px_x),
        .m_px_y       (m_px_y),
        .m_has_pixel  (m_has_pixel),
        .m_last       (m_last)
    );

endmodule

// ===== bench/tb_triangle_scanline_rasterizer.sv =====
`timescale 1ns / 100ps

module tb_triangle_scanline_rasterizer;
    import tsr_pkg::*;

    localparam int CB      = COORD_BITS_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    // cycles to let a load finish its row search before touching registers
    localparam int SETTLE  = 10000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_cmd;
    logic signed [CB-1:0] s_vertex_a_x, s_vertex_a_y;
    logic signed [CB-1:0] s_vertex_b_x, s_vertex_b_y;
    logic signed [CB-1:0] s_vertex_c_x, s_vertex_c_y;
    logic                 m_valid;
    logic                 m_ready;
    logic [PX_BITS-1:0]   m_px_x, m_px_y;
    logic                 m_has_pixel, m_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [CFG_BITS-1:0]  cfg_data;

    triangle_scanline_rasterizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_vertex_a_x(s_vertex_a_x), .s_vertex_a_y(s_vertex_a_y),
        .s_vertex_b_x(s_vertex_b_x), .s_vertex_b_y(s_vertex_b_y),
        .s_vertex_c_x(s_vertex_c_x), .s_vertex_c_y(s_vertex_c_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_px_x(m_px_x), .m_px_y(m_px_y), .m_has_pixel(m_has_pixel), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    typedef struct {
        logic [PX_BITS-1:0] px_x;
        logic [PX_BITS-1:0] px_y;
        logic               has_pixel;
        logic               last;
    } pixel_t;

    pixel_t pending_pixels[$];

    int  errors      = 0;
    int  items_sent  = 0;
    int  pixels_seen = 0;
    int  loads_sent  = 0;
    bit  quiet       = 0;   // no idling while set
    int  hold_off    = 0;   // long receiver stall request

    // ---------------- rasterizer shadow state ----------------
    logic [CFG_BITS-1:0] sh_width, sh_height;
    longint sv_x[3], sv_y[3];
    longint sh_mid, sh_lslope, sh_rslope, sh_row, sh_col, sh_end;
    int     sh_half;
    bit     sh_active;

    function automatic longint clamp_dim(logic [CFG_BITS-1:0] v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return longint'(v);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint base_lo();
        return (sv_x[1] < sh_mid) ? sv_x[1] : sh_mid;
    endfunction

    function automatic longint base_hi();
        return (sv_x[1] < sh_mid) ? sh_mid : sv_x[1];
    endfunction

    function automatic bit span_of_row(longint r, output longint l, output longint rr);
        longint w, d, xl, xr;
        w  = clamp_dim(sh_width);
        d  = r - sv_y[1];
        xl = (sh_lslope * d + base_lo() * (64'sd1 << FB)) / (64'sd1 << FB);
        xr = (sh_rslope * d + base_hi() * (64'sd1 << FB)) / (64'sd1 << FB);
        l = 0;
        rr = 0;
        if (xl >= w) return 0;
        if (xl < 0) xl = 0;
        if (xr < 0) return 0;
        if (xr >= w) xr = w - 1;
        if (xl > xr) return 0;
        l = xl;
        rr = xr;
        return 1;
    endfunction

    // advance to the first covered pixel at or after row r of half h
    function automatic void find_next_pixel(int h, longint r, bit from_start);
        longint ax, ay, by, dy, lo, hi, ht, l, rr;
        forever begin
            ax = h ? sv_x[2] : sv_x[0];
            ay = h ? sv_y[2] : sv_y[0];
            by = sv_y[1];
            dy = ay - by;
            if (dy == 0) begin
                sh_lslope = 0;
                sh_rslope = 0;
            end else begin
                sh_lslope = clamp32(((ax - base_lo()) * (64'sd1 << FB)) / dy);
                sh_rslope = clamp32(((ax - base_hi()) * (64'sd1 << FB)) / dy);
            end
            lo = (ay < by) ? ay : by;
            hi = (ay < by) ? by : ay;
            ht = clamp_dim(sh_height);
            if (from_start) r = lo;
            if (r < 0) r = 0;
            if (hi > ht - 1) hi = ht - 1;
            for (; r <= hi; r++) begin
                if (span_of_row(r, l, rr)) begin
                    sh_half = h;
                    sh_row = r;
                    sh_col = l;
                    sh_end = rr;
                    sh_active = 1;
                    return;
                end
            end
            if (h == 1) begin
                sh_active = 0;
                return;
            end
            h = 1;
            from_start = 1;
        end
    endfunction

    function automatic void shadow_reset();
        sh_width = WIDTH_RESET;
        sh_height = HEIGHT_RESET;
        for (int i = 0; i < 3; i++) begin
            sv_x[i] = 0;
            sv_y[i] = 0;
        end
        sh_mid = 0; sh_half = 0; sh_lslope = 0; sh_rslope = 0;
        sh_row = 0; sh_col = 0; sh_end = 0; sh_active = 0;
    endfunction

    // update shadow state for one accepted beat; queue the pixel that a step returns
    function automatic void predict_beat(logic cmd, longint ax, longint ay, longint bx,
                                         longint by, longint cx, longint cy);
        longint t, d;
        pixel_t p;
        if (cmd == CMD_LOAD) begin
            if (ay < by) begin t = ax; ax = bx; bx = t; t = ay; ay = by; by = t; end
            if (by < cy) begin t = bx; bx = cx; cx = t; t = by; by = cy; cy = t; end
            if (ay < by) begin t = ax; ax = bx; bx = t; t = ay; ay = by; by = t; end
            sv_x[0] = ax; sv_y[0] = ay;
            sv_x[1] = bx; sv_y[1] = by;
            sv_x[2] = cx; sv_y[2] = cy;
            d = ay - cy;
            sh_half = 0; sh_lslope = 0; sh_rslope = 0;
            sh_row = 0; sh_col = 0; sh_end = 0;
            if (d == 0) begin
                sh_mid = cx;
                sh_active = 0;
                return;
            end
            sh_mid = ((by - cy) * (ax - cx) + cx * d) / d;
            find_next_pixel(0, 0, 1);
            return;
        end
        if (!sh_active) begin
            p = '{px_x: '0, px_y: '0, has_pixel: 1'b0, last: 1'b0};
        end else begin
            p.px_x = sh_col[PX_BITS-1:0];
            p.px_y = sh_row[PX_BITS-1:0];
            p.has_pixel = 1'b1;
            if (sh_col < sh_end) sh_col++;
            else find_next_pixel(sh_half, sh_row + 1, 0);
            p.last = !sh_active;
        end
        pending_pixels.push_back(p);
    endfunction

    // ---------------- clock, reset, limit ----------------
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60ms;
        $display("timeout waiting for beats");
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- input side ----------------
    task automatic send_beat(logic cmd, logic signed [CB-1:0] ax, logic signed [CB-1:0] ay,
                             logic signed [CB-1:0] bx, logic signed [CB-1:0] by,
                             logic signed [CB-1:0] cx, logic signed [CB-1:0] cy);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_vertex_a_x <= ax; s_vertex_a_y <= ay;
        s_vertex_b_x <= bx; s_vertex_b_y <= by;
        s_vertex_c_x <= cx; s_vertex_c_y <= cy;
        do @(posedge aclk); while (!s_ready);
        predict_beat(cmd, ax, ay, bx, by, cx, cy);
        items_sent++;
        if (cmd == CMD_LOAD) loads_sent++;
    endtask

    task automatic step_beat();
        send_beat(CMD_STEP, CB'($urandom), CB'($urandom), CB'($urandom),
                  CB'($urandom), CB'($urandom), CB'($urandom));
    endtask

    task automatic load_beat(int ax, int ay, int bx, int by, int cx, int cy);
        send_beat(CMD_LOAD, CB'(ax), CB'(ay), CB'(bx), CB'(by), CB'(cx), CB'(cy));
    endtask

    // step through the current triangle until done, capped, plus up to two more steps after
    task automatic walk_triangle(int cap);
        int n;
        n = 0;
        while (sh_active && n < cap) begin
            step_beat();
            n++;
        end
        repeat ($urandom_range(0, 2)) step_beat();
    endtask

    // random triangle: mostly small and near the frame, sometimes anywhere
    task automatic random_triangle();
        int ox, oy, sz, kind;
        int v[6];
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            foreach (v[i]) v[i] = $signed(13'($urandom));
        end else begin
            ox = $urandom_range(0, clamp_dim(sh_width) + 40) - 20;
            oy = $urandom_range(0, clamp_dim(sh_height) + 40) - 20;
            sz = (kind < 4) ? 2 : 25;
            for (int i = 0; i < 3; i++) begin
                v[2*i]   = ox + $urandom_range(0, 2*sz) - sz;
                v[2*i+1] = oy + $urandom_range(0, 2*sz) - sz;
            end
            // flat top or bottom now and then
            if (kind == 5) v[3] = v[1];
            if (kind == 6) v[5] = v[3];
            if (kind == 7) begin v[3] = v[1]; v[5] = v[1]; end
        end
        load_beat(v[0], v[1], v[2], v[3], v[4], v[5]);
    endtask

    task automatic finish_burst();
        s_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pixels.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_WIDTH) sh_width = val;
        else sh_height = val;
    endtask

    // ---------------- output side ----------------
    initial begin : pixel_checker
        int gap;
        pixel_t p;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 3);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                $error("pixel beat with nothing expected");
                errors++;
            end else begin
                p = pending_pixels.pop_front();
                if (m_px_x !== p.px_x) begin
                    $error("px_x expected %0d actual %0d", p.px_x, m_px_x);
                    errors++;
                end
                if (m_px_y !== p.px_y) begin
                    $error("px_y expected %0d actual %0d", p.px_y, m_px_y);
                    errors++;
                end
                if (m_has_pixel !== p.has_pixel) begin
                    $error("has_pixel expected %0d actual %0d", p.has_pixel, m_has_pixel);
                    errors++;
                end
                if (m_last !== p.last) begin
                    $error("last expected %0d actual %0d", p.last, m_last);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed();
        // no triangle yet
        step_beat();
        // extreme corners, mostly off frame
        load_beat(-4096, -4096, 4095, 4095, -4096, 4095);
        walk_triangle(6);
        load_beat(4095, -4096, -4096, 4095, 4095, 4095);
        walk_triangle(4);
        // single row
        load_beat(10, 20, 30, 20, 50, 20);
        step_beat();
        // flat top then flat bottom (one half of zero height)
        load_beat(5, 10, 15, 10, 10, 4);
        walk_triangle(200);
        load_beat(5, 4, 15, 4, 10, 10);
        walk_triangle(200);
        // clipped against left, bottom and right
        load_beat(-5, -3, 3, 2, 650, 478);
        walk_triangle(8);
        // replace a triangle in progress
        load_beat(0, 0, 4, 3, 1, 6);
        step_beat();
        step_beat();
        load_beat(2, 2, 3, 3, 2, 3);
        walk_triangle(50);
        finish_burst();
        wait_idle();
    endtask

    task automatic run_triangles(int count);
        repeat (count) begin
            random_triangle();
            walk_triangle($urandom_range(0, 9) == 0 ? 8 : 30);
        end
    endtask

    task automatic test_frame_sizes();
        logic [CFG_BITS-1:0] sizes[8][2] = '{
            '{13'd1, 13'd1}, '{13'd0, 13'd0}, '{13'd4096, 13'd4096},
            '{13'h1FFF, 13'h1FFF}, '{13'd17, 13'd9}, '{13'd4097, 13'd3},
            '{13'd2, 13'd4095}, '{WIDTH_RESET, HEIGHT_RESET}};
        foreach (sizes[i]) begin
            write_reg(CFG_WIDTH, sizes[i][0]);
            write_reg(CFG_HEIGHT, sizes[i][1]);
            quiet = (i == 2);
            run_triangles(3);
            finish_burst();
            wait_idle();
        end
        quiet = 0;
    endtask

    task automatic test_backpressure();
        load_beat(100, 100, 140, 120, 110, 150);
        hold_off = 400;
        quiet = 1;
        repeat (40) step_beat();
        quiet = 0;
        walk_triangle(60);
        finish_burst();
        wait_idle();
    endtask

    task automatic test_random_mix();
        while (items_sent < 1450) begin
            if ($urandom_range(0, 9) == 0) step_beat();
            else begin
                random_triangle();
                walk_triangle($urandom_range(0, 5) == 0 ? $urandom_range(0, 6) : 100);
            end
        end
        finish_burst();
    endtask

    initial begin
        shadow_reset();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = CMD_STEP;
        s_vertex_a_x = '0; s_vertex_a_y = '0;
        s_vertex_b_x = '0; s_vertex_b_y = '0;
        s_vertex_c_x = '0; s_vertex_c_y = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_frame_sizes();
        test_backpressure();
        test_random_mix();

        while (pending_pixels.size() > 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("%0d beats in (%0d loads), %0d pixel beats checked, 8 frame sizes",
                 items_sent, loads_sent, pixels_seen);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

endmodule
